### design/spiral_tiling_cell_generator_top_macros.svh
// Assertion macros used by the tiling cell generator checker.
`ifndef SPIRAL_TILING_CELL_GENERATOR_TOP_MACROS_SVH
`define SPIRAL_TILING_CELL_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define STCG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define STCG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/stcg_pkg.sv
// Shared types and constants of the spiral tiling cell generator.
package stcg_pkg;

	localparam int unsigned CfgIdxBits  = 3;
	localparam int unsigned CfgDataBits = 15;

	localparam logic [CfgIdxBits-1:0] RegOutputX      = 3'd0;
	localparam logic [CfgIdxBits-1:0] RegOutputY      = 3'd1;
	localparam logic [CfgIdxBits-1:0] RegOutputWidth  = 3'd2;
	localparam logic [CfgIdxBits-1:0] RegOutputHeight = 3'd3;
	localparam logic [CfgIdxBits-1:0] RegGapSize      = 3'd4;
	localparam logic [CfgIdxBits-1:0] RegMinSize      = 3'd5;
	localparam logic [CfgIdxBits-1:0] RegSpiralMode   = 3'd6;

	// Split steps: left half, top half, right half, bottom half
	localparam logic [1:0] DirLeft   = 2'd0;
	localparam logic [1:0] DirTop    = 2'd1;
	localparam logic [1:0] DirRight  = 2'd2;
	localparam logic [1:0] DirBottom = 2'd3;

	typedef struct packed {
		logic signed [14:0] output_x;
		logic signed [14:0] output_y;
		logic [13:0]        output_width;
		logic [13:0]        output_height;
		logic [7:0]         gap_size;
		logic [7:0]         min_size;
		logic               spiral_mode;
	} cfg_t;

	typedef struct packed {
		logic [14:0] free_width;
		logic [14:0] free_height;
		logic [1:0]  split_direction;
	} free_size_t;

	typedef struct packed {
		logic        first_window;
		logic        last_window;
		logic [14:0] current_width;
		logic [14:0] current_height;
	} item_t;

	typedef struct packed {
		logic [15:0] cell_x;
		logic [15:0] cell_y;
		logic [14:0] cell_width;
		logic [14:0] cell_height;
		logic        needs_resize;
	} result_t;

endpackage

### design/stcg_cfg_regs.sv
// Configuration register file of the tiling cell generator.
module stcg_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [stcg_pkg::CfgIdxBits-1:0]     cfg_idx,
	input  logic [stcg_pkg::CfgDataBits-1:0]    cfg_data,
	output stcg_pkg::cfg_t                      cfg
);

	stcg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_x      <= 15'sd0;
			cfg_q.output_y      <= 15'sd0;
			cfg_q.output_width  <= 14'd1920;
			cfg_q.output_height <= 14'd1080;
			cfg_q.gap_size      <= 8'd0;
			cfg_q.min_size      <= 8'd32;
			cfg_q.spiral_mode   <= 1'b1;
		end else if (cfg_wen) begin
			case (cfg_idx)
				stcg_pkg::RegOutputX:      cfg_q.output_x      <= cfg_data;
				stcg_pkg::RegOutputY:      cfg_q.output_y      <= cfg_data;
				stcg_pkg::RegOutputWidth:  cfg_q.output_width  <= cfg_data[13:0];
				stcg_pkg::RegOutputHeight: cfg_q.output_height <= cfg_data[13:0];
				stcg_pkg::RegGapSize:      cfg_q.gap_size      <= cfg_data[7:0];
				stcg_pkg::RegMinSize:      cfg_q.min_size      <= cfg_data[7:0];
				stcg_pkg::RegSpiralMode:   cfg_q.spiral_mode   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/stcg_layout.sv
// Combinational split of the free rectangle into one window cell.
module stcg_layout #(
	parameter int unsigned COORD_BITS = 16
) (
	input  stcg_pkg::cfg_t                  cfg,
	input  stcg_pkg::item_t                 item,
	input  logic signed [COORD_BITS-1:0]    free_x,
	input  logic signed [COORD_BITS-1:0]    free_y,
	input  stcg_pkg::free_size_t            free_size,
	output logic signed [COORD_BITS-1:0]    next_free_x,
	output logic signed [COORD_BITS-1:0]    next_free_y,
	output stcg_pkg::free_size_t            next_free_size,
	output stcg_pkg::result_t               result
);

	logic [6:0]                  half_gap;
	logic [31:0]                 ox_ext, oy_ext;
	logic [15:0]                 rw_diff, rh_diff;
	logic signed [COORD_BITS-1:0] fx, fy, cx, cy;
	logic [14:0]                 fw, fh, cw, ch, half_w, half_h;
	logic [1:0]                  dir, step;
	logic [31:0]                 cx_ext, cy_ext;
	logic [15:0]                 cw_diff, ch_diff;
	logic [14:0]                 cw_fin, ch_fin;

	assign half_gap = cfg.gap_size[7:1];
	assign ox_ext   = 32'(cfg.output_x);
	assign oy_ext   = 32'(cfg.output_y);
	assign rw_diff  = {2'b00, cfg.output_width} - {8'd0, cfg.gap_size};
	assign rh_diff  = {2'b00, cfg.output_height} - {8'd0, cfg.gap_size};

	always_comb begin
		// reload from the output area, shrunk by one gap
		if (item.first_window) begin
			fx  = ox_ext[COORD_BITS-1:0] + COORD_BITS'(half_gap);
			fy  = oy_ext[COORD_BITS-1:0] + COORD_BITS'(half_gap);
			fw  = rw_diff[15] ? 15'd0 : rw_diff[14:0];
			fh  = rh_diff[15] ? 15'd0 : rh_diff[14:0];
			dir = 2'd0;
		end else begin
			fx  = free_x;
			fy  = free_y;
			fw  = free_size.free_width;
			fh  = free_size.free_height;
			dir = free_size.split_direction;
		end
		half_w = {1'b0, fw[14:1]};
		half_h = {1'b0, fh[14:1]};
		step   = cfg.spiral_mode ? dir : {1'b0, dir[0]};

		cx = fx;
		cy = fy;
		cw = fw;
		ch = fh;
		next_free_x = fx;
		next_free_y = fy;
		next_free_size.free_width  = fw;
		next_free_size.free_height = fh;
		next_free_size.split_direction = dir + 2'd1;

		if (!item.last_window) begin
			case (step)
				stcg_pkg::DirLeft: begin
					cw = half_w;
					next_free_x = fx + COORD_BITS'(half_w);
					next_free_size.free_width = fw - half_w;
				end
				stcg_pkg::DirTop: begin
					ch = half_h;
					next_free_y = fy + COORD_BITS'(half_h);
					next_free_size.free_height = fh - half_h;
				end
				stcg_pkg::DirRight: begin
					cw = half_w;
					cx = fx + COORD_BITS'(fw - half_w);
					next_free_size.free_width = fw - half_w;
				end
				default: begin
					ch = half_h;
					cy = fy + COORD_BITS'(fh - half_h);
					next_free_size.free_height = fh - half_h;
				end
			endcase
		end
	end

	assign cx_ext  = 32'(cx);
	assign cy_ext  = 32'(cy);
	assign cw_diff = {1'b0, cw} - {8'd0, cfg.gap_size};
	assign ch_diff = {1'b0, ch} - {8'd0, cfg.gap_size};

	// raise to the minimum size; a negative difference always takes the floor
	assign cw_fin = ($signed(cw_diff) < $signed({8'd0, cfg.min_size}))
		? {7'd0, cfg.min_size} : cw_diff[14:0];
	assign ch_fin = ($signed(ch_diff) < $signed({8'd0, cfg.min_size}))
		? {7'd0, cfg.min_size} : ch_diff[14:0];

	assign result.cell_x       = cx_ext[15:0] + {9'd0, half_gap};
	assign result.cell_y       = cy_ext[15:0] + {9'd0, half_gap};
	assign result.cell_width   = cw_fin;
	assign result.cell_height  = ch_fin;
	assign result.needs_resize = (item.current_width != cw_fin) ||
		(item.current_height != ch_fin);

endmodule

### design/spiral_tiling_cell_generator_top.sv
// Top level of the spiral tiling cell generator.
// An input item passes the input register, then the result register, to the master side.
// One item per cycle unless m_tready stalls; free rectangle updates in one registered pass.
// Input and result registers decouple the sides; one item is taken while a result waits.
// Reset (arst_n low, asynchronous): registers to defaults, free rectangle zero, stages empty.
module spiral_tiling_cell_generator_top #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [stcg_pkg::CfgIdxBits-1:0]     cfg_idx,
	input  logic [stcg_pkg::CfgDataBits-1:0]    cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// current_width [14:0], current_height [29:15], zero [31:30]
	input  logic [31:0]                         s_tdata,
	input  logic                                s_tlast,  // last_window
	// first_window [0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// cell_x [15:0], cell_y [31:16], cell_width [46:32], cell_height [61:47],
	// needs_resize [62], zero [63]
	output logic [63:0]                         m_tdata
);

	stcg_pkg::cfg_t       cfg;
	stcg_pkg::item_t      item_s1;
	logic                 valid_s1;
	logic                 advance;
	logic signed [COORD_BITS-1:0] free_x_q, free_y_q, next_free_x, next_free_y;
	stcg_pkg::free_size_t free_size_q, next_free_size;
	stcg_pkg::result_t    result, result_q;
	logic                 m_valid_q;

	stcg_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.first_window   <= s_tuser;
			item_s1.last_window    <= s_tlast;
			item_s1.current_width  <= s_tdata[14:0];
			item_s1.current_height <= s_tdata[29:15];
		end
	end

	stcg_layout #(
		.COORD_BITS (COORD_BITS)
	) u_layout (
		.cfg            (cfg),
		.item           (item_s1),
		.free_x         (free_x_q),
		.free_y         (free_y_q),
		.free_size      (free_size_q),
		.next_free_x    (next_free_x),
		.next_free_y    (next_free_y),
		.next_free_size (next_free_size),
		.result         (result)
	);

	// commit the free rectangle only when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_x_q    <= '0;
			free_y_q    <= '0;
			free_size_q <= '0;
		end else if (advance) begin
			free_x_q    <= next_free_x;
			free_y_q    <= next_free_y;
			free_size_q <= next_free_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, result_q.needs_resize, result_q.cell_height,
		result_q.cell_width, result_q.cell_y, result_q.cell_x};

endmodule

### design/stcg_checker.sv
// Port-level checker for the tiling cell generator, bound to the top level.
`include "spiral_tiling_cell_generator_top_macros.svh"

module stcg_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [63:0]                         m_tdata
);

	// a stalled result holds
	`STCG_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result dropped or changed")

	// an empty output side never stalls the input side
	`STCG_ASSERT_NOW(a_in_ready, !m_tvalid, s_tready, "input stalled with output empty")

	// an item taken while the output side is empty shows up as a result
	`STCG_ASSERT_NXT(a_in_to_out, s_tvalid && s_tready && !m_tvalid, ##1 m_tvalid, "accepted item produced no result")

	// cell sizes stay within the 14-bit size range and the top bit stays zero
	`STCG_ASSERT_NOW(a_size_range, m_tvalid, !m_tdata[46] && !m_tdata[61] && !m_tdata[63], "cell size out of range")

endmodule

bind spiral_tiling_cell_generator_top stcg_checker u_stcg_checker (.*);

### test/spiral_tiling_cell_generator_top_test.sv
// Self-checking testbench for the spiral tiling cell generator: directed table, then random runs.
module spiral_tiling_cell_generator_top_test;
	import stcg_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int PhaseItems = 250;
	localparam int Phases     = 8;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
		logic [1:0]         step;
	} free_rect_t;

	typedef struct {
		bit                    is_reg;
		logic [CfgIdxBits-1:0] idx;
		logic [14:0]           data;
		item_t                 it;
		bit                    has_want;
		result_t               want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wen = 1'b0;
	logic [CfgIdxBits-1:0]  cfg_idx = '0;
	logic [CfgDataBits-1:0] cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [31:0]            s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [63:0]            m_tdata;

	spiral_tiling_cell_generator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	cfg_t       layout_regs;
	free_rect_t free_area;
	result_t    expected_cells[$];
	stim_row_t  plan[$];
	int         mismatches = 0;
	int         cells_seen = 0;
	int         cycles = 0;
	int         gap_pct = 0;
	int         stall_pct = 0;
	bit         cfg_active = 0;
	result_t    got_cell;
	result_t    want_cell;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int fit_size(input int v);
		if (v < 0)
			return 0;
		if (v > 32767)
			return 32767;
		return v;
	endfunction

	// Place one window in the free rectangle and advance the rectangle.
	function automatic result_t place_window(input item_t it, inout free_rect_t st,
			input cfg_t c);
		int         gap, hg, fx, fy, fw, fh, cx, cy, cw, ch, half, floor_sz;
		logic [1:0] dir;
		result_t    r;
		gap = int'(c.gap_size);
		hg = gap >> 1;
		floor_sz = int'(c.min_size);
		if (it.first_window) begin
			st.x = 16'(int'($signed(c.output_x)) + hg);
			st.y = 16'(int'($signed(c.output_y)) + hg);
			st.w = 15'(fit_size(int'(c.output_width) - gap));
			st.h = 15'(fit_size(int'(c.output_height) - gap));
			st.step = 2'd0;
		end
		fx = int'($signed(st.x));
		fy = int'($signed(st.y));
		fw = int'(st.w);
		fh = int'(st.h);
		cx = fx;
		cy = fy;
		cw = fw;
		ch = fh;
		if (!it.last_window) begin
			dir = c.spiral_mode ? st.step : {1'b0, st.step[0]};
			case (dir)
			DirLeft: begin
				half = fw >> 1;
				cw = half;
				st.x = 16'(fx + half);
				st.w = 15'(fw - half);
			end
			DirTop: begin
				half = fh >> 1;
				ch = half;
				st.y = 16'(fy + half);
				st.h = 15'(fh - half);
			end
			DirRight: begin
				half = fw >> 1;
				cw = half;
				cx = fx + fw - half;
				st.w = 15'(fw - half);
			end
			DirBottom: begin
				half = fh >> 1;
				ch = half;
				cy = fy + fh - half;
				st.h = 15'(fh - half);
			end
			endcase
		end
		st.step = st.step + 2'd1;
		cw = cw - gap;
		ch = ch - gap;
		if (cw < floor_sz)
			cw = floor_sz;
		if (ch < floor_sz)
			ch = floor_sz;
		r.cell_x = 16'(cx + hg);
		r.cell_y = 16'(cy + hg);
		r.cell_width = 15'(fit_size(cw));
		r.cell_height = 15'(fit_size(ch));
		r.needs_resize = (it.current_width != r.cell_width) || (it.current_height != r.cell_height);
		return r;
	endfunction

	function automatic void plan_reg(input logic [CfgIdxBits-1:0] idx, input logic [14:0] data);
		stim_row_t row;
		row.is_reg = 1;
		row.idx = idx;
		row.data = data;
		row.it = '0;
		row.has_want = 0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_item(input bit f, input bit l, input int cw, input int ch);
		stim_row_t row;
		row.is_reg = 0;
		row.idx = '0;
		row.data = '0;
		row.it.first_window = f;
		row.it.last_window = l;
		row.it.current_width = 15'(cw);
		row.it.current_height = 15'(ch);
		row.has_want = 0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_check(input bit f, input bit l, input int cw, input int ch,
			input int x, input int y, input int w, input int h, input bit nr);
		plan_item(f, l, cw, ch);
		plan[$].has_want = 1;
		plan[$].want.cell_x = 16'(x);
		plan[$].want.cell_y = 16'(y);
		plan[$].want.cell_width = 15'(w);
		plan[$].want.cell_height = 15'(h);
		plan[$].want.needs_resize = nr;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on cell %0d, %s: got %0d, expected %0d", cells_seen, what, got, want);
		mismatches++;
	endtask

	// Hold the sender until every pending cell has come out.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CfgIdxBits-1:0] idx, input logic [14:0] data);
		if (!cfg_active) begin
			drain_results();
			cfg_active = 1;
		end
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
		RegOutputX:      layout_regs.output_x = data[14:0];
		RegOutputY:      layout_regs.output_y = data[14:0];
		RegOutputWidth:  layout_regs.output_width = data[13:0];
		RegOutputHeight: layout_regs.output_height = data[13:0];
		RegGapSize:      layout_regs.gap_size = data[7:0];
		RegMinSize:      layout_regs.min_size = data[7:0];
		RegSpiralMode:   layout_regs.spiral_mode = data[0];
		default:         ;
		endcase
	endtask

	task automatic send_item(input item_t it, input bit has_want, input result_t want);
		result_t pred;
		pred = place_window(it, free_area, layout_regs);
		expected_cells.push_back(has_want ? want : pred);
		if (cfg_active) begin
			cfg_wen <= 1'b0;
			cfg_active = 0;
		end
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, it.current_height, it.current_width};
		s_tuser <= it.first_window;
		s_tlast <= it.last_window;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("spiral_tiling_cell_generator_top_test NOT OK");
			$finish;
		end
	end

	// Compare every cell transfer with the oldest pending prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_cell.cell_x = m_tdata[15:0];
			got_cell.cell_y = m_tdata[31:16];
			got_cell.cell_width = m_tdata[46:32];
			got_cell.cell_height = m_tdata[61:47];
			got_cell.needs_resize = m_tdata[62];
			if (expected_cells.size() == 0) begin
				report_mismatch("cell_x with nothing pending",
					longint'($signed(got_cell.cell_x)), longint'(0));
			end else begin
				want_cell = expected_cells.pop_front();
				if (got_cell.cell_x !== want_cell.cell_x)
					report_mismatch("cell_x", longint'($signed(got_cell.cell_x)),
						longint'($signed(want_cell.cell_x)));
				if (got_cell.cell_y !== want_cell.cell_y)
					report_mismatch("cell_y", longint'($signed(got_cell.cell_y)),
						longint'($signed(want_cell.cell_y)));
				if (got_cell.cell_width !== want_cell.cell_width)
					report_mismatch("cell_width", longint'(got_cell.cell_width),
						longint'(want_cell.cell_width));
				if (got_cell.cell_height !== want_cell.cell_height)
					report_mismatch("cell_height", longint'(got_cell.cell_height),
						longint'(want_cell.cell_height));
				if (got_cell.needs_resize !== want_cell.needs_resize)
					report_mismatch("needs_resize", longint'(got_cell.needs_resize),
						longint'(want_cell.needs_resize));
			end
			cells_seen++;
		end
	end

	initial begin
		int         phase, n, run_left, run_pos;
		item_t      it;
		free_rect_t probe;
		result_t    guess;
		logic [14:0] ox, oy, ow, oh, gp, mn, sp;

		layout_regs.output_x = '0;
		layout_regs.output_y = '0;
		layout_regs.output_width = 14'd1920;
		layout_regs.output_height = 14'd1080;
		layout_regs.gap_size = 8'd0;
		layout_regs.min_size = 8'd32;
		layout_regs.spiral_mode = 1'b1;
		free_area = '0;
		run_left = 0;
		run_pos = 0;

		// no first window yet: zero free area, cell clamps to min size
		plan_check(0, 0, 32, 32, 0, 0, 32, 32, 0);
		plan_check(1, 1, 1920, 1080, 0, 0, 1920, 1080, 0);
		plan_check(1, 0, 0, 0, 0, 0, 960, 1080, 1);
		plan_check(0, 0, 960, 540, 960, 0, 960, 540, 0);
		plan_check(0, 0, 32767, 32767, 1440, 540, 480, 540, 1);
		plan_check(0, 0, 480, 270, 960, 810, 480, 270, 0);
		plan_check(0, 1, 0, 32767, 960, 540, 480, 270, 1);
		// dwindle: left and top only
		plan_reg(RegSpiralMode, 15'd0);
		plan_check(1, 0, 960, 1080, 0, 0, 960, 1080, 0);
		plan_check(0, 0, 0, 0, 960, 0, 960, 540, 1);
		plan_check(0, 0, 480, 540, 960, 540, 480, 540, 0);
		plan_check(0, 0, 1, 1, 1440, 540, 480, 270, 1);
		plan_check(0, 1, 480, 270, 1440, 810, 480, 270, 0);
		// output narrower than the gap, gap wider than the cell
		plan_reg(RegGapSize, 15'd255);
		plan_reg(RegMinSize, 15'd1);
		plan_reg(RegOutputWidth, 15'd100);
		plan_check(1, 1, 1, 1, 254, 254, 1, 570, 1);
		plan_reg(RegMinSize, 15'd0);
		plan_check(1, 0, 0, 0, 254, 254, 0, 570, 1);
		plan_item(0, 0, 0, 0);
		// coordinate extremes
		plan_reg(RegOutputX, 15'h4000);
		plan_reg(RegOutputY, 15'h3FFF);
		plan_reg(RegOutputWidth, 15'h3FFF);
		plan_reg(RegOutputHeight, 15'h3FFF);
		plan_reg(RegGapSize, 15'd0);
		plan_reg(RegMinSize, 15'd255);
		plan_reg(RegSpiralMode, 15'd1);
		plan_item(1, 0, 255, 255);
		plan_item(0, 0, 32767, 0);
		plan_item(0, 0, 0, 32767);
		plan_item(0, 0, 100, 100);
		plan_item(0, 0, 8191, 8191);
		plan_item(0, 1, 4096, 4096);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_reg)
				set_reg(plan[i].idx, plan[i].data);
			else
				send_item(plan[i].it, plan[i].has_want, plan[i].want);
		end

		for (phase = 0; phase < Phases; phase++) begin
			case (phase)
			0: begin
				ox = '0; oy = '0; ow = 15'd1920; oh = 15'd1080;
				gp = '0; mn = 15'd32; sp = 15'd1;
			end
			1: begin
				ox = 15'h3FFF; oy = 15'h3FFF; ow = 15'h3FFF; oh = 15'h3FFF;
				gp = 15'd255; mn = 15'd255; sp = 15'd1;
			end
			2: begin
				ox = 15'h4000; oy = 15'h4000; ow = '0; oh = '0;
				gp = '0; mn = '0; sp = '0;
			end
			default: begin
				ox = 15'($urandom);
				oy = 15'($urandom);
				ow = ($urandom_range(3) == 0) ? 15'($urandom_range(16383)) : 15'($urandom_range(1, 3000));
				oh = ($urandom_range(3) == 0) ? 15'($urandom_range(16383)) : 15'($urandom_range(1, 3000));
				gp = ($urandom_range(3) == 0) ? 15'($urandom_range(255)) : 15'($urandom_range(16));
				mn = 15'($urandom_range(255));
				sp = 15'($urandom_range(1));
			end
			endcase
			set_reg(RegOutputX, ox);
			set_reg(RegOutputY, oy);
			set_reg(RegOutputWidth, ow);
			set_reg(RegOutputHeight, oh);
			set_reg(RegGapSize, gp);
			set_reg(RegMinSize, mn);
			set_reg(RegSpiralMode, sp);

			case (phase % 4)
			0: begin gap_pct = 0; stall_pct = 0; end
			1: begin gap_pct = 46; stall_pct = 0; end
			2: begin gap_pct = 0; stall_pct = 46; end
			default: begin gap_pct = 13; stall_pct = 13; end
			endcase

			for (n = 0; n < PhaseItems; n++) begin
				if (n == PhaseItems / 2)
					drain_results();
				// mostly whole runs of windows: first, middles, last
				if (run_left == 0 && $urandom_range(99) < 85) begin
					run_left = $urandom_range(1, 10);
					run_pos = 0;
				end
				if (run_left != 0) begin
					it.first_window = (run_pos == 0);
					it.last_window = (run_left == 1);
					run_left--;
					run_pos++;
				end else begin
					it.first_window = 1'($urandom_range(1));
					it.last_window = 1'($urandom_range(1));
				end
				it.current_width = '0;
				it.current_height = '0;
				probe = free_area;
				guess = place_window(it, probe, layout_regs);
				case ($urandom_range(9))
				0, 1, 2, 3: begin
					it.current_width = guess.cell_width;
					it.current_height = guess.cell_height;
				end
				4, 5: begin
					it.current_width = guess.cell_width + 15'($urandom_range(1));
					it.current_height = guess.cell_height + 15'($urandom_range(1));
				end
				6: begin
					it.current_width = $urandom_range(1) ? 15'h7FFF : 15'h0000;
					it.current_height = $urandom_range(1) ? 15'h7FFF : 15'h0000;
				end
				default: begin
					it.current_width = 15'($urandom);
					it.current_height = 15'($urandom);
				end
				endcase
				send_item(it, 1'b0, guess);
			end
		end

		s_tvalid <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("spiral_tiling_cell_generator_top_test OK");
		else
			$display("spiral_tiling_cell_generator_top_test NOT OK");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/stcg_pkg.sv
design/stcg_cfg_regs.sv
design/stcg_layout.sv
design/spiral_tiling_cell_generator_top.sv
design/stcg_checker.sv
test/spiral_tiling_cell_generator_top_test.sv
